FILE: design/lattice_link_cache_macros.svh
// Assertion macros shared by the checker of the link cache.
`ifndef LATTICE_LINK_CACHE_MACROS_SVH
`define LATTICE_LINK_CACHE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lattice link cache check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lattice link cache check failed");

`endif

FILE: design/llc_pkg.sv
`default_nettype none

package llc_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int DIMS      = 4;
  localparam int EXT_W     = 6;
  localparam int NODE_W    = 7;
  localparam int COORD_W   = 12;
  localparam int SLOT_W    = 6;
  localparam int BUCKET_W  = 22;
  localparam int OWNER_W   = 24;
  localparam int AGE_W     = 32;
  localparam int DIV_W     = EXT_W + NODE_W;
  localparam int STEP_W    = $clog2(DIV_W);
  localparam int OP_W      = 4;

  localparam logic [1:0] REQ_LOOKUP     = 2'd0;
  localparam logic [1:0] REQ_CLEAR_SITE = 2'd1;
  localparam logic [1:0] REQ_CLEAR_ALL  = 2'd2;

  localparam logic [2:0] REG_EXT_0  = 3'd0;
  localparam logic [2:0] REG_EXT_1  = 3'd1;
  localparam logic [2:0] REG_EXT_2  = 3'd2;
  localparam logic [2:0] REG_EXT_3  = 3'd3;
  localparam logic [2:0] REG_NODE_0 = 3'd4;
  localparam logic [2:0] REG_NODE_1 = 3'd5;
  localparam logic [2:0] REG_NODE_2 = 3'd6;
  localparam logic [2:0] REG_NODE_3 = 3'd7;

  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV_G    = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_E    = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd4;
  localparam logic [OP_W-1:0] OP_ACCUM    = 4'd5;
  localparam logic [OP_W-1:0] OP_SCAN     = 4'd6;
  localparam logic [OP_W-1:0] OP_STACK_RD = 4'd7;
  localparam logic [OP_W-1:0] OP_FILL     = 4'd8;
  localparam logic [OP_W-1:0] OP_TOUCH    = 4'd9;
  localparam logic [OP_W-1:0] OP_PUSH     = 4'd10;
  localparam logic [OP_W-1:0] OP_RESULT   = 4'd11;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic [1:0]                link_dir;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fill_needed;
    logic                evicted;
    logic [BUCKET_W-1:0] bucket;
    logic [OWNER_W-1:0]  owner_node;
  } rsp_t;

  typedef struct packed {
    logic [DIMS-1:0][EXT_W-1:0]  ext;
    logic [DIMS-1:0][NODE_W-1:0] nodes;
  } cfg_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [OWNER_W-1:0]  owner;
    logic [AGE_W-1:0]    fill_age;
    logic [AGE_W-1:0]    use_age;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic       div_last;
    logic       dim_last;
    logic       scan_done;
    logic       hit;
    logic       found;
    logic       empty;
    logic [1:0] req_type;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/llc_ctrl.sv
`default_nettype none

module llc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  llc_pkg::sts_t sts,
  output llc_pkg::cmd_t cmd
);
  import llc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV_G    = 4'd1;
  localparam logic [3:0] S_STEP_G   = 4'd2;
  localparam logic [3:0] S_DIV_E    = 4'd3;
  localparam logic [3:0] S_STEP_E   = 4'd4;
  localparam logic [3:0] S_ACCUM    = 4'd5;
  localparam logic [3:0] S_DISPATCH = 4'd6;
  localparam logic [3:0] S_SCAN     = 4'd7;
  localparam logic [3:0] S_DECIDE   = 4'd8;
  localparam logic [3:0] S_FILL     = 4'd9;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_DIV_G;
        end
      end
      S_DIV_G: begin
        cmd.op     = OP_DIV_G;
        state_next = S_STEP_G;
      end
      S_STEP_G: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) state_next = S_DIV_E;
      end
      S_DIV_E: begin
        cmd.op     = OP_DIV_E;
        state_next = S_STEP_E;
      end
      S_STEP_E: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.op     = OP_ACCUM;
        state_next = sts.dim_last ? S_DISPATCH : S_DIV_G;
      end
      S_DISPATCH: begin
        priority case (sts.req_type)
          REQ_LOOKUP, REQ_CLEAR_SITE, REQ_CLEAR_ALL: begin
            cmd.op     = OP_SCAN;
            state_next = S_SCAN;
          end
          default: begin
            cmd.op     = OP_RESULT;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.req_type == REQ_LOOKUP) begin
          priority if (sts.hit) begin
            cmd.op     = OP_TOUCH;
            state_next = S_IDLE;
          end else if (!sts.empty) begin
            cmd.op     = OP_STACK_RD;
            state_next = S_FILL;
          end else begin
            cmd.op     = OP_FILL;
            state_next = S_IDLE;
          end
        end else if (sts.found) begin
          cmd.op     = OP_PUSH;
          state_next = S_DISPATCH;
        end else begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.op     = OP_FILL;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/llc_dp.sv
`default_nettype none

module llc_dp #(
  parameter int SLOTS = llc_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  llc_pkg::cmd_t cmd,
  input  llc_pkg::req_t req,
  input  llc_pkg::cfg_t cfg,
  output llc_pkg::sts_t sts,
  output llc_pkg::rsp_t result,
  output logic          done
);
  import llc_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0]     LAST_SLOT  = IW'(SLOTS - 1);
  localparam logic [CW-1:0]     FULL_COUNT = CW'(SLOTS);
  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_W - 1);

  req_t                      req_q;
  logic [1:0]                dim;
  logic signed [COORD_W-1:0] x;
  logic [EXT_W-1:0]          ext_eff;
  logic [NODE_W-1:0]         nc_eff;
  logic [DIV_W-1:0]          glob, x_ext, x_abs, folded;
  logic [DIV_W-1:0]          num, quo, divisor;
  logic [DIV_W:0]            rem, trial, rem_next;
  logic                      ge, neg;
  logic [STEP_W-1:0]         step;
  logic [BUCKET_W-1:0]       bacc, bucket;
  logic [OWNER_W-1:0]        oacc;
  logic [BUCKET_W+EXT_W-1:0] bprod;
  logic [OWNER_W+NODE_W-1:0] oprod;
  logic [AGE_W-1:0]          age, du, df;

  entry_t           mem [SLOTS];
  entry_t           rd_word, wr_word;
  logic             mem_we;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    stack [SLOTS];
  logic [IW-1:0]    stk_rd;
  logic [SLOTS-1:0] valid;
  logic [CW-1:0]    count, low_mark, cm1;
  logic             empty;

  logic [IW-1:0]       scan_addr, rd_idx, best, hit_slot, fill_slot;
  logic                scan_on, rd_vld, found, hit_q, match, take, v;
  logic [AGE_W-1:0]    best_dist;
  logic [BUCKET_W-1:0] best_bucket;
  entry_t              hit_word;

  // Per-dimension operand selection, coordinate folding, divider step and accumulator products.
  always_comb begin
    unique case (dim)
      2'd0:    x = req_q.coord_0;
      2'd1:    x = req_q.coord_1;
      2'd2:    x = req_q.coord_2;
      default: x = req_q.coord_3;
    endcase
    ext_eff = (cfg.ext[dim] == '0) ? EXT_W'(1) : cfg.ext[dim];
    nc_eff  = (cfg.nodes[dim] == '0) ? NODE_W'(1) : cfg.nodes[dim];
    glob    = DIV_W'(ext_eff) * DIV_W'(nc_eff);
    x_ext   = DIV_W'(x);
    x_abs   = x[COORD_W-1] ? (~x_ext + DIV_W'(1)) : x_ext;
    folded  = (neg && rem[DIV_W-1:0] != '0) ? (glob - rem[DIV_W-1:0]) : rem[DIV_W-1:0];
    trial    = {rem[DIV_W-1:0], num[DIV_W-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? (trial - {1'b0, divisor}) : trial;
    bprod    = bacc * ext_eff;
    oprod    = oacc * nc_eff;
  end

  assign bucket = {bacc[BUCKET_W-3:0], req_q.link_dir};

  // Scan candidate evaluation on the registered entry word.
  always_comb begin
    v     = valid[rd_idx];
    du    = age - rd_word.use_age;
    df    = age - rd_word.fill_age;
    match = v && rd_word.bucket == bucket && rd_word.owner == oacc;
    unique case (req_q.req_type)
      REQ_LOOKUP:     take = v && (!found || df > best_dist);
      REQ_CLEAR_SITE: take = v && rd_word.bucket == bucket && (!found || du > best_dist);
      REQ_CLEAR_ALL:  take = v && (!found || rd_word.bucket < best_bucket ||
                             (rd_word.bucket == best_bucket && du > best_dist));
      default:        take = 1'b0;
    endcase
  end

  assign cm1       = count - CW'(1);
  assign empty     = (count == '0);
  assign fill_slot = empty ? best : ((count == low_mark) ? cm1[IW-1:0] : stk_rd);

  always_comb begin
    mem_we  = (cmd.op == OP_FILL) || (cmd.op == OP_TOUCH);
    wr_addr = (cmd.op == OP_TOUCH) ? hit_slot : fill_slot;
    if (cmd.op == OP_TOUCH) begin
      wr_word         = hit_word;
      wr_word.use_age = age;
    end else begin
      wr_word = '{bucket: bucket, owner: oacc, fill_age: age, use_age: age};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_word;
    rd_word <= mem[scan_addr];
    if (cmd.op == OP_PUSH && count < FULL_COUNT) stack[count[IW-1:0]] <= best;
    stk_rd <= stack[cm1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      count    <= FULL_COUNT;
      low_mark <= FULL_COUNT;
      age      <= '0;
      scan_on  <= 1'b0;
      rd_vld   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= scan_on;
      if (scan_on && scan_addr == LAST_SLOT) scan_on <= 1'b0;
      unique case (cmd.op)
        OP_SCAN: scan_on <= 1'b1;
        OP_FILL: begin
          valid[fill_slot] <= 1'b1;
          age              <= age + AGE_W'(1);
          done             <= 1'b1;
          if (!empty) begin
            count <= cm1;
            if (count == low_mark) low_mark <= cm1;
          end
        end
        OP_TOUCH: begin
          age  <= age + AGE_W'(1);
          done <= 1'b1;
        end
        OP_PUSH: begin
          valid[best] <= 1'b0;
          if (count < FULL_COUNT) count <= count + CW'(1);
        end
        OP_RESULT: done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        req_q <= req;
        dim   <= 2'd3;
        bacc  <= '0;
        oacc  <= '0;
      end
      OP_DIV_G: begin
        num     <= x_abs;
        rem     <= '0;
        divisor <= glob;
        step    <= '0;
        neg     <= x[COORD_W-1];
      end
      OP_DIV_E: begin
        num     <= folded;
        rem     <= '0;
        divisor <= DIV_W'(ext_eff);
        step    <= '0;
      end
      OP_DIV_STEP: begin
        num  <= num << 1;
        rem  <= rem_next;
        quo  <= {quo[DIV_W-2:0], ge};
        step <= step + STEP_W'(1);
      end
      OP_ACCUM: begin
        bacc <= bprod[BUCKET_W-1:0] + BUCKET_W'(rem[EXT_W-1:0]);
        oacc <= oprod[OWNER_W-1:0] + OWNER_W'(quo[NODE_W-1:0]);
        dim  <= dim - 2'd1;
      end
      OP_SCAN: begin
        scan_addr <= '0;
        found     <= 1'b0;
        hit_q     <= 1'b0;
      end
      OP_FILL: begin
        result <= '{hit: 1'b0, slot: SLOT_W'(fill_slot), fill_needed: 1'b1,
                    evicted: empty, bucket: bucket, owner_node: oacc};
      end
      OP_TOUCH: begin
        result <= '{hit: 1'b1, slot: SLOT_W'(hit_slot), fill_needed: 1'b0,
                    evicted: 1'b0, bucket: bucket, owner_node: oacc};
      end
      OP_RESULT: begin
        result <= '{hit: 1'b0, slot: '0, fill_needed: 1'b0,
                    evicted: 1'b0, bucket: bucket, owner_node: oacc};
      end
      default: ;
    endcase
    if (scan_on) begin
      scan_addr <= scan_addr + IW'(1);
      rd_idx    <= scan_addr;
    end
    if (rd_vld) begin
      if (match && !hit_q && req_q.req_type == REQ_LOOKUP) begin
        hit_q    <= 1'b1;
        hit_slot <= rd_idx;
        hit_word <= rd_word;
      end
      if (take) begin
        found       <= 1'b1;
        best        <= rd_idx;
        best_bucket <= rd_word.bucket;
        best_dist   <= (req_q.req_type == REQ_LOOKUP) ? df : du;
      end
    end
  end

  assign sts = '{div_last: (step == DIV_LAST), dim_last: (dim == 2'd0),
                 scan_done: (rd_vld && rd_idx == LAST_SLOT), hit: hit_q,
                 found: found, empty: empty, req_type: req_q.req_type};

endmodule

`default_nettype wire

FILE: design/lattice_link_cache.sv
`default_nettype none

// Tag store of a cache of off-node lattice links. A request is taken when
// start is high while busy is low; exactly one result word follows, shown on
// result for the single cycle in which done is high. The receiver cannot
// stall, so it must capture result in that cycle. Each coordinate is reduced
// by a shared restoring divider, one quotient bit per cycle, first to fold
// it into the global extent and then to split it into node and local
// coordinate, after which both are accumulated, for each of the four
// dimensions. The slot store is then swept one slot per cycle through its
// single read port. A lookup that misses while a free slot is left passes
// through a stack read state before the fill. A clear sweeps once per freed
// slot plus a final sweep. An unused request type only computes bucket and
// owner. In every case done is raised in the first cycle in which busy is
// low, and a new request may be taken in that cycle. The user must write
// configuration through the APB port only while busy is low; the block
// itself does not enforce this. There is no clearing pass after reset: the
// first request may follow at once.
module lattice_link_cache #(
  parameter int SLOTS = llc_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  llc_pkg::req_t req,
  output logic          done,
  output llc_pkg::rsp_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import llc_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register file: four local extents followed by four node counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ext   <= {DIMS{EXT_W'(4)}};
      cfg.nodes <= {DIMS{NODE_W'(1)}};
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_EXT_0:  cfg.ext[0]   <= pwdata[EXT_W-1:0];
        REG_EXT_1:  cfg.ext[1]   <= pwdata[EXT_W-1:0];
        REG_EXT_2:  cfg.ext[2]   <= pwdata[EXT_W-1:0];
        REG_EXT_3:  cfg.ext[3]   <= pwdata[EXT_W-1:0];
        REG_NODE_0: cfg.nodes[0] <= pwdata[NODE_W-1:0];
        REG_NODE_1: cfg.nodes[1] <= pwdata[NODE_W-1:0];
        REG_NODE_2: cfg.nodes[2] <= pwdata[NODE_W-1:0];
        REG_NODE_3: cfg.nodes[3] <= pwdata[NODE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXT_0:  prdata = 32'(cfg.ext[0]);
      REG_EXT_1:  prdata = 32'(cfg.ext[1]);
      REG_EXT_2:  prdata = 32'(cfg.ext[2]);
      REG_EXT_3:  prdata = 32'(cfg.ext[3]);
      REG_NODE_0: prdata = 32'(cfg.nodes[0]);
      REG_NODE_1: prdata = 32'(cfg.nodes[1]);
      REG_NODE_2: prdata = 32'(cfg.nodes[2]);
      REG_NODE_3: prdata = 32'(cfg.nodes[3]);
    endcase
  end

  // The controller sequences folding, sweeps and updates; the datapath holds
  // the divider, the slot store, the free-slot stack and the result word.
  llc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  llc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .cfg    (cfg),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

endmodule

`default_nettype wire

FILE: design/llc_checker.sv
`default_nettype none
`include "lattice_link_cache_macros.svh"

module llc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result word only closes a request that was in flight.
  `LLC_ASSERT_NOW(a_done_after_busy, done, $past(busy))
  // An accepted word keeps the block busy on the next cycle.
  `LLC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // No result can come back in the cycle right after acceptance.
  `LLC_ASSERT_NEXT(a_accept_no_done, start && !busy, !done)
  // Each request yields one single-cycle strobe.
  `LLC_ASSERT_NEXT(a_done_single, done, !done)

endmodule

bind lattice_link_cache llc_checker u_llc_checker (.*);

`default_nettype wire

FILE: tb/sv/llc_checker.sv
`timescale 1ns / 100ps
`default_nettype none

// Watches the request and result channels and the register port of the link
// cache, keeps its own copy of the tag store and compares every result word.
module tb_llc_checker #(
  parameter int SLOTS = llc_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire llc_pkg::req_t req,
  input  wire logic          done,
  input  wire llc_pkg::rsp_t result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  input  wire logic          pready,
  output int                 errors,
  output int                 pending,
  output int                 hits,
  output int                 evictions
);
  import llc_pkg::*;

  logic [EXT_W-1:0]    ext_reg  [DIMS];
  logic [NODE_W-1:0]   node_reg [DIMS];
  bit                  valid_tag [SLOTS];
  logic [BUCKET_W-1:0] tag_bucket [SLOTS];
  logic [OWNER_W-1:0]  tag_owner [SLOTS];
  logic [AGE_W-1:0]    fill_stamp [SLOTS];
  logic [AGE_W-1:0]    use_stamp [SLOTS];
  logic [AGE_W-1:0]    stamp_now;
  int                  free_slots [SLOTS];
  int                  free_top;
  rsp_t                expected_words [$];

  function automatic longint wrap_mod(longint x, longint m);
    longint r;
    r = x % m;
    return (r < 0) ? r + m : r;
  endfunction

  function automatic logic [AGE_W-1:0] age_of(logic [AGE_W-1:0] stamp);
    return stamp_now - stamp;
  endfunction

  function automatic void release_slot(int s);
    if (free_top < SLOTS) begin
      free_slots[free_top] = s;
      free_top++;
    end
    valid_tag[s] = 1'b0;
  endfunction

  // Works out the result word of one request and updates the tag store.
  function automatic rsp_t cache_access(req_t r);
    rsp_t   o;
    longint x, e, n, bsum, bstride, nsum, nstride;
    int     best;
    bit     found;
    o = '0;
    bsum = 0;
    bstride = 4;
    nsum = 0;
    nstride = 1;
    for (int d = 0; d < DIMS; d++) begin
      case (d)
        0: x = longint'(r.coord_0);
        1: x = longint'(r.coord_1);
        2: x = longint'(r.coord_2);
        default: x = longint'(r.coord_3);
      endcase
      e = (ext_reg[d] == 0) ? 1 : longint'(ext_reg[d]);
      n = (node_reg[d] == 0) ? 1 : longint'(node_reg[d]);
      bsum += wrap_mod(x, e) * bstride;
      nsum += (wrap_mod(x, e * n) / e) * nstride;
      bstride *= e;
      nstride *= n;
    end
    bsum += longint'(r.link_dir);
    o.bucket = bsum[BUCKET_W-1:0];
    o.owner_node = nsum[OWNER_W-1:0];

    if (r.req_type == REQ_LOOKUP) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!o.hit && valid_tag[s] && tag_bucket[s] == o.bucket &&
            tag_owner[s] == o.owner_node) begin
          o.hit = 1'b1;
          o.slot = s[SLOT_W-1:0];
        end
      end
      if (o.hit) begin
        use_stamp[o.slot] = stamp_now;
        stamp_now++;
      end else begin
        o.fill_needed = 1'b1;
        if (free_top > 0) begin
          free_top--;
          best = free_slots[free_top] % SLOTS;
        end else begin
          // No free slot left, so the slot filled longest ago is replaced.
          o.evicted = 1'b1;
          best = 0;
          found = 0;
          for (int s = 0; s < SLOTS; s++) begin
            if (valid_tag[s] && (!found || age_of(fill_stamp[s]) > age_of(fill_stamp[best])))
            begin
              best = s;
              found = 1;
            end
          end
        end
        o.slot = best[SLOT_W-1:0];
        valid_tag[best] = 1'b1;
        tag_bucket[best] = o.bucket;
        tag_owner[best] = o.owner_node;
        fill_stamp[best] = stamp_now;
        use_stamp[best] = stamp_now;
        stamp_now++;
      end
    end else if (r.req_type == REQ_CLEAR_SITE || r.req_type == REQ_CLEAR_ALL) begin
      // Slots are released one at a time, least recently used first; a full
      // clear orders by ascending bucket first and by use age within a bucket.
      do begin
        best = 0;
        found = 0;
        for (int s = 0; s < SLOTS; s++) begin
          if (valid_tag[s] && !(r.req_type == REQ_CLEAR_SITE && tag_bucket[s] != o.bucket))
          begin
            if (!found ||
                (r.req_type == REQ_CLEAR_ALL && tag_bucket[s] < tag_bucket[best]) ||
                ((r.req_type == REQ_CLEAR_SITE || tag_bucket[s] == tag_bucket[best]) &&
                 age_of(use_stamp[s]) > age_of(use_stamp[best]))) begin
              best = s;
              found = 1;
            end
          end
        end
        if (found) release_slot(best);
      end while (found);
    end
    return o;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int d = 0; d < DIMS; d++) begin
        ext_reg[d] <= 4;
        node_reg[d] <= 1;
      end
      for (int s = 0; s < SLOTS; s++) begin
        valid_tag[s] = 1'b0;
        free_slots[s] = s;
      end
      free_top = SLOTS;
      stamp_now = '0;
      expected_words.delete();
      errors <= 0;
      hits <= 0;
      evictions <= 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("unexpected result word %p", result);
          errors <= errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (result !== want) begin
            if (errors < 10) $display("result mismatch: expected %p, got %p", want, result);
            errors <= errors + 1;
          end
          if (want.hit) hits <= hits + 1;
          if (want.evicted) evictions <= evictions + 1;
        end
      end
      if (start && !busy) expected_words.push_back(cache_access(req));
      if (psel && penable && pwrite && pready) begin
        if (paddr[4:2] < REG_NODE_0) ext_reg[paddr[3:2]] <= pwdata[EXT_W-1:0];
        else node_reg[paddr[3:2]] <= pwdata[NODE_W-1:0];
      end
    end
  end
endmodule

`default_nettype wire

FILE: tb/sv/tb_lattice_link_cache.sv
`timescale 1ns / 100ps
`default_nettype none

// Stimulus and verdict for the link cache. The checker beside the block does
// all prediction and comparison; this module only drives requests and the
// register port, and decides pass or fail at the end.
module tb_lattice_link_cache;
  import llc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending, hits, evictions;
  int          words_sent;
  int          idle_pct;
  req_t        recent_links [$];

  lattice_link_cache DUT (.*);

  tb_llc_checker u_checker (
    .clk, .rst, .start, .busy, .req, .done, .result, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .errors, .pending, .hits, .evictions
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Even if every word were a full clear of a full store after the longest
  // idle gap, this bound would be about ten times what a correct run needs.
  initial begin
    #2_000_000_000;
    $display("simulation failed");
    $finish;
  end

  // Writes one register through a setup and an access cycle.
  task automatic write_reg(logic [2:0] index, int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every expected word has come back and the block is idle.
  task automatic drain;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Registers change only with the block idle and nothing outstanding.
  task automatic set_geometry(int e0, int e1, int e2, int e3,
                              int n0, int n1, int n2, int n3);
    drain();
    write_reg(REG_EXT_0, e0);
    write_reg(REG_EXT_1, e1);
    write_reg(REG_EXT_2, e2);
    write_reg(REG_EXT_3, e3);
    write_reg(REG_NODE_0, n0);
    write_reg(REG_NODE_1, n1);
    write_reg(REG_NODE_2, n2);
    write_reg(REG_NODE_3, n3);
  endtask

  // Presents one request word and holds it until the block takes it. start
  // is left high so the next word can follow without a gap.
  task automatic send_word(req_t w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 250)) @(posedge clk);
    end
    start <= 1'b1;
    req <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  function automatic req_t make_req(logic [1:0] kind, int c0, int c1, int c2, int c3,
                                    int dir);
    req_t w;
    w.req_type = kind;
    w.coord_0 = c0[COORD_W-1:0];
    w.coord_1 = c1[COORD_W-1:0];
    w.coord_2 = c2[COORD_W-1:0];
    w.coord_3 = c3[COORD_W-1:0];
    w.link_dir = dir[1:0];
    return w;
  endfunction

  // Most words revisit a pool of recent links, so hits, refills after a
  // clear and evictions of a full store all happen often. The pool is larger
  // than the store, which keeps the replacement path busy.
  function automatic req_t random_req();
    req_t w;
    int   pick;
    pick = $urandom_range(999);
    if (recent_links.size() > 0 && pick < 550) begin
      w = recent_links[$urandom_range(recent_links.size() - 1)];
      w.req_type = REQ_LOOKUP;
    end else begin
      w = make_req(REQ_LOOKUP, $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(4095), $urandom_range(3));
      if ($urandom_range(1)) begin
        // Small coordinates land in a narrow set of buckets.
        w.coord_0 = COORD_W'($urandom_range(7) - 4);
        w.coord_1 = COORD_W'($urandom_range(7) - 4);
        w.coord_2 = COORD_W'($urandom_range(3));
        w.coord_3 = COORD_W'($urandom_range(3));
      end
      recent_links.push_back(w);
      if (recent_links.size() > 96) void'(recent_links.pop_front());
    end
    // Clears and the unused request type use a newly made link, not one from the pool.
    if (pick >= 940 && pick < 985) w.req_type = REQ_CLEAR_SITE;
    else if (pick >= 985 && pick < 993) w.req_type = REQ_CLEAR_ALL;
    else if (pick >= 993) w.req_type = 2'd3;
    return w;
  endfunction

  task automatic random_phase(int count, int idle);
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      // Once in each phase the sender stops until everything is back.
      if (i == count / 2) begin
        start <= 1'b0;
        drain();
      end
      send_word(random_req());
    end
    start <= 1'b0;
  endtask

  initial begin
    words_sent = 0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset geometry: coordinate extremes, repeated
    // lookups that hit, a clear of one site, an unused request type and a
    // full clear of a store holding several buckets.
    send_word(make_req(REQ_LOOKUP, -2048, -2048, -2048, -2048, 0));
    send_word(make_req(REQ_LOOKUP, 2047, 2047, 2047, 2047, 3));
    send_word(make_req(REQ_LOOKUP, -2048, -2048, -2048, -2048, 0));
    send_word(make_req(REQ_LOOKUP, 0, 0, 0, 0, 0));
    send_word(make_req(REQ_LOOKUP, -1, -1, -1, -1, 1));
    send_word(make_req(REQ_LOOKUP, 4, 8, -4, 12, 0));
    send_word(make_req(REQ_LOOKUP, 2047, 2047, 2047, 2047, 3));
    send_word(make_req(REQ_LOOKUP, 1, 2, 3, 0, 2));
    send_word(make_req(REQ_CLEAR_SITE, 0, 0, 0, 0, 0));
    send_word(make_req(REQ_LOOKUP, 0, 0, 0, 0, 0));
    send_word(make_req(REQ_CLEAR_SITE, 5, 5, 5, 5, 2));
    send_word(make_req(2'd3, -2048, 2047, -1, 0, 3));
    send_word(make_req(REQ_CLEAR_ALL, 0, 0, 0, 0, 0));
    send_word(make_req(REQ_LOOKUP, -1, -1, -1, -1, 1));
    send_word(make_req(REQ_CLEAR_ALL, 2047, -2048, 2047, -2048, 3));
    start <= 1'b0;

    random_phase(300, 0);

    // Smallest geometry: one site and one node everywhere, so every link of
    // a direction shares one bucket and owner.
    set_geometry(1, 1, 1, 1, 1, 1, 1, 1);
    send_word(make_req(REQ_LOOKUP, 1234, -777, 5, -2048, 2));
    send_word(make_req(REQ_LOOKUP, 0, 0, 0, 0, 2));
    start <= 1'b0;
    random_phase(300, 49);

    // Largest geometry whose ids fit: the bucket and owner ids reach their widest values.
    set_geometry(32, 32, 32, 32, 64, 64, 64, 64);
    send_word(make_req(REQ_LOOKUP, -1, -1, -1, -1, 3));
    send_word(make_req(REQ_LOOKUP, 2047, 2047, 2047, 2047, 3));
    start <= 1'b0;
    random_phase(350, 0);

    set_geometry(3, 5, 2, 7, 2, 3, 1, 4);
    random_phase(350, 19);

    set_geometry($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
                 $urandom_range(1, 32), $urandom_range(1, 64), $urandom_range(1, 64),
                 $urandom_range(1, 64), $urandom_range(1, 64));
    random_phase(380, 49);

    // Let any stray word show up before the verdict.
    drain();
    repeat (300) @(posedge clk);

    $display("Sent %0d request words over five geometries, smallest and largest included.",
             words_sent);
    $display("Saw %0d hits and %0d evictions of the oldest fill.", hits, evictions);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/llc_pkg.sv
design/llc_ctrl.sv
design/llc_dp.sv
design/lattice_link_cache.sv
design/llc_checker.sv
tb/sv/llc_checker.sv
tb/sv/tb_lattice_link_cache.sv
